// ===== src/ascii_decimal_list_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII decimal list parser.
// Each macro expands to a labeled concurrent assertion, or to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_LIST_PARSER_CORE_MACROS_SVH
`define ASCII_DECIMAL_LIST_PARSER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define ADLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ADLP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ADLP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ADLP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/adlp_pkg.sv =====
// ----------------------------------------------------------------------------
// adlp_pkg
// Shared constants and types of the ASCII decimal list parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adlp_pkg;

  // Number of fields kept per frame; later numbers are dropped.
  localparam int unsigned MAX_FIELDS   = 8;
  // Largest fraction digit count before it saturates.
  localparam int unsigned MAX_FRACTION = 31;
  localparam int unsigned FRAC_CAP     = (MAX_FRACTION > 31) ? 31 : MAX_FRACTION;

  // Width of the per-frame field counter, able to hold MAX_FIELDS itself.
  localparam int unsigned FIELD_W = $clog2(MAX_FIELDS + 1);

  localparam int unsigned ACC_W  = 31;
  localparam int unsigned MANT_W = 32;
  localparam int unsigned FRAC_W = 5;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned BYTE_W = 8;

  // Character codes.
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

  // Reset value of the end marker register: '@'.
  localparam logic [BYTE_W-1:0] END_MARKER_RESET = 8'h40;

  // Largest mantissa magnitude.
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // One result transaction.
  typedef struct packed {
    logic                     has_value;
    logic signed [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0]        fraction_digits;
    logic [IDX_W-1:0]         field_index;
    logic                     overflowed;
    logic                     frame_last;
  } result_t;

endpackage

// ===== src/adlp_parse.sv =====
// ----------------------------------------------------------------------------
// adlp_parse
// Number accumulation state and the combinational decode of one text byte
// into an optional result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adlp_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic [adlp_pkg::BYTE_W-1:0]   byte_i,
  input  logic [adlp_pkg::BYTE_W-1:0]   end_marker_i,
  output logic                          emit_o,
  output adlp_pkg::result_t             result_o
);

  logic [adlp_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic                         neg_q, neg_d;
  logic                         point_q, point_d;
  logic [adlp_pkg::FRAC_W-1:0]  frac_q, frac_d;
  logic                         pending_q, pending_d;
  logic                         sat_q, sat_d;
  logic [adlp_pkg::FIELD_W-1:0] fields_q, fields_d;

  logic                         is_digit;
  logic                         numeric;
  logic                         closes;
  logic                         room;
  logic                         emit_value;
  logic [adlp_pkg::ACC_W+3:0]   acc_times_ten;
  logic [adlp_pkg::ACC_W+3:0]   acc_next;
  logic                         mant_ovf;
  logic [adlp_pkg::ACC_W-1:0]   acc_step;
  logic [adlp_pkg::MANT_W-1:0]  mant_signed;

  // Byte classification.
  assign is_digit = (byte_i >= adlp_pkg::CHAR_ZERO) && (byte_i <= adlp_pkg::CHAR_NINE);
  assign numeric  = is_digit || (byte_i == adlp_pkg::CHAR_POINT)
                    || (byte_i == adlp_pkg::CHAR_MINUS);
  assign closes   = (byte_i == end_marker_i) || (byte_i == adlp_pkg::CHAR_NUL);
  assign room     = fields_q < adlp_pkg::FIELD_W'(adlp_pkg::MAX_FIELDS);

  // Decimal accumulate: acc * 10 + digit, built from two shifts.
  assign acc_times_ten = {3'b000, acc_q, 1'b0} + {1'b0, acc_q, 3'b000};
  assign acc_next      = acc_times_ten + {31'd0, byte_i[3:0] - adlp_pkg::CHAR_ZERO[3:0]};
  assign mant_ovf      = acc_next > {4'd0, adlp_pkg::ACC_MAX};
  assign acc_step      = mant_ovf ? adlp_pkg::ACC_MAX : acc_next[adlp_pkg::ACC_W-1:0];

  // Two's complement of the magnitude when a minus sign was seen.
  assign mant_signed = neg_q ? (adlp_pkg::MANT_W'(0) - {1'b0, acc_q}) : {1'b0, acc_q};

  assign emit_value = !(numeric && !closes) && pending_q && room;
  assign emit_o     = !(numeric && !closes) && (closes || (pending_q && room));

  // Result fields; all but frame_last are zero when no number is carried.
  always_comb begin
    result_o                 = '0;
    result_o.frame_last      = closes;
    if (emit_value) begin
      result_o.has_value       = 1'b1;
      result_o.mantissa        = mant_signed;
      result_o.fraction_digits = frac_q;
      result_o.field_index     = adlp_pkg::IDX_W'(fields_q);
      result_o.overflowed      = sat_q;
    end
  end

  // Next state of the number being built and the field counter.
  always_comb begin
    acc_d     = acc_q;
    neg_d     = neg_q;
    point_d   = point_q;
    frac_d    = frac_q;
    pending_d = pending_q;
    sat_d     = sat_q;
    fields_d  = fields_q;
    if (numeric && !closes) begin
      pending_d = 1'b1;
      if (point_q) begin
        if (frac_q < adlp_pkg::FRAC_W'(adlp_pkg::FRAC_CAP)) begin
          frac_d = frac_q + 1'b1;
        end else begin
          sat_d = 1'b1;
        end
      end
      if (byte_i == adlp_pkg::CHAR_MINUS) begin
        neg_d = 1'b1;
      end else if (byte_i == adlp_pkg::CHAR_POINT) begin
        point_d = 1'b1;
      end else begin
        acc_d = acc_step;
        if (mant_ovf) begin
          sat_d = 1'b1;
        end
      end
    end else begin
      if (pending_q) begin
        if (room) begin
          fields_d = fields_q + 1'b1;
        end
        acc_d     = '0;
        neg_d     = 1'b0;
        point_d   = 1'b0;
        frac_d    = '0;
        pending_d = 1'b0;
        sat_d     = 1'b0;
      end
      if (closes) begin
        fields_d = '0;
      end
    end
  end

  // State registers, updated on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      neg_q     <= 1'b0;
      point_q   <= 1'b0;
      frac_q    <= '0;
      pending_q <= 1'b0;
      sat_q     <= 1'b0;
      fields_q  <= '0;
    end else if (take_i) begin
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      point_q   <= point_d;
      frac_q    <= frac_d;
      pending_q <= pending_d;
      sat_q     <= sat_d;
      fields_q  <= fields_d;
    end
  end

endmodule

// ===== src/ascii_decimal_list_parser_core.sv =====
// ----------------------------------------------------------------------------
// ascii_decimal_list_parser_core
// Streaming parser that turns received text into signed decimal numbers with
// a fraction digit count and a field index.
// ----------------------------------------------------------------------------
// The core takes one text byte per clock cycle and can accept a byte in every
// cycle it is not stalled. A byte is decoded in the cycle it is accepted, and
// its result, if any, is on the result port at the earliest on the next cycle.
// Results pass through a two-entry output queue, so input keeps flowing while
// one result waits; the input stalls only when both queue entries hold
// results. The end marker register may be written at any time the parser is
// idle; it is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ascii_decimal_list_parser_core_macros.svh"

module ascii_decimal_list_parser_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [adlp_pkg::BYTE_W-1:0]         cfg_end_marker_i,
  // Text input channel.
  input  logic                                text_valid_i,
  output logic                                text_stall_o,
  input  logic [adlp_pkg::BYTE_W-1:0]         text_byte_i,
  // Result channel.
  output logic                                result_valid_o,
  input  logic                                result_stall_i,
  output logic                                has_value_o,
  output logic signed [adlp_pkg::MANT_W-1:0]  mantissa_o,
  output logic [adlp_pkg::FRAC_W-1:0]         fraction_digits_o,
  output logic [adlp_pkg::IDX_W-1:0]          field_index_o,
  output logic                                overflowed_o,
  output logic                                frame_last_o
);

  logic [adlp_pkg::BYTE_W-1:0] end_marker_q;
  logic                        take;
  logic                        emit;
  logic                        push;
  logic                        pop;
  adlp_pkg::result_t           new_result;
  adlp_pkg::result_t           head_q, head_d;
  adlp_pkg::result_t           skid_q, skid_d;
  logic                        head_valid_q, head_valid_d;
  logic                        skid_valid_q, skid_valid_d;

  // End marker register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_marker_q <= adlp_pkg::END_MARKER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      end_marker_q <= cfg_end_marker_i;
    end
  end

  // Input transaction and byte decode.
  assign text_stall_o = skid_valid_q;
  assign take         = text_valid_i && !text_stall_o;

  adlp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .byte_i       (text_byte_i),
    .end_marker_i (end_marker_q),
    .emit_o       (emit),
    .result_o     (new_result)
  );

  assign push = take && emit;
  assign pop  = head_valid_q && !result_stall_i;

  // Two-entry output queue: head drives the port, skid catches overflow.
  always_comb begin
    head_d       = head_q;
    skid_d       = skid_q;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!head_valid_q || pop) begin
      head_d       = new_result;
      head_valid_d = push;
    end else if (push) begin
      skid_d       = new_result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  // Result port.
  assign result_valid_o    = head_valid_q;
  assign has_value_o       = head_q.has_value;
  assign mantissa_o        = head_q.mantissa;
  assign fraction_digits_o = head_q.fraction_digits;
  assign field_index_o     = head_q.field_index;
  assign overflowed_o      = head_q.overflowed;
  assign frame_last_o      = head_q.frame_last;

  // The skid entry is only ever filled behind a held head entry.
  `ADLP_ASSERT_IMP(a_skid_behind_head, clk_i, rst_ni, skid_valid_q, head_valid_q)

  // A result that does not close a frame always carries a number.
  `ADLP_ASSERT_IMP(a_value_or_last, clk_i, rst_ni, result_valid_o, has_value_o || frame_last_o)

  // An empty result has all number fields cleared.
  `ADLP_ASSERT_IMP(a_empty_is_zero, clk_i, rst_ni, result_valid_o && !has_value_o, (mantissa_o == '0) && (fraction_digits_o == '0) && (field_index_o == '0) && !overflowed_o)

  // A full queue that is drained moves the skid result to the head.
  `ADLP_ASSERT_NXT(a_skid_drain, clk_i, rst_ni, skid_valid_q && !result_stall_i, head_valid_q && !skid_valid_q)

endmodule
